// ----- design/ths_pkg.sv -----
// ----------------------------------------------------------------------------
// ths_pkg: shared types and constants for the three-axis homing sequencer
// Request, result and configuration payloads, phase codes and reset values.
// ----------------------------------------------------------------------------
package ths_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int OUT_POS_W     = 32;
    localparam int PERIOD_W      = 16;
    localparam int SETTLE_W      = 24;
    localparam int STEPS_W       = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int PHASE_W       = 3;

    // axis phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEEK    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BACKOFF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_BACKOFF_PER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_XY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_Z     = 3'd4;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD   = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_Z_BACKOFF_PER = 16'd200;
    localparam logic [SETTLE_W-1:0] RST_SETTLE        = 24'd500000;
    localparam logic [STEPS_W-1:0]  RST_BACKOFF_XY    = 16'd2000;
    localparam logic [STEPS_W-1:0]  RST_BACKOFF_Z     = 16'd150;

    typedef struct packed {
        logic start_req;
        logic x_max_open;
        logic y_max_open;
        logic z_min_open;
    } tick_t;

    typedef struct packed {
        logic                        x_step;
        logic                        x_dir;
        logic                        y_step;
        logic                        y_dir;
        logic                        z_step;
        logic                        z_dir;
        logic                        homed;
        logic signed [OUT_POS_W-1:0] x_pos;
        logic signed [OUT_POS_W-1:0] y_pos;
        logic signed [OUT_POS_W-1:0] z_pos;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    // per-tick control from the sequencer to one axis
    typedef struct packed {
        logic tick;      // a request is accepted this cycle
        logic arm;       // a run starts on this request
        logic arm_seek;  // armed axis goes straight to seek
        logic resume;    // a waiting axis may begin seeking
    } axis_ctrl_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               step;
        logic               dir;
    } axis_stat_t;

endpackage

// ----- design/ths_chan_if.sv -----
// ----------------------------------------------------------------------------
// ths_chan_if: valid/ready channel
// Carries one payload of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface ths_chan_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- design/three_axis_homing_sequencer.sv -----
// ----------------------------------------------------------------------------
// three_axis_homing_sequencer: homes Z, then X and Y in parallel
// One time-base tick per request; one result per tick.
// ----------------------------------------------------------------------------
// result: the result of a request is registered and valid in the cycle after it is accepted
// throughput: one request per clock while the result is taken, since each axis
// state updates on every accepted request; a pending result does not block the next request when taken
// reset: all axes idle, counters and positions zero, registers at defaults
module three_axis_homing_sequencer #(
    parameter int POS_WIDTH = ths_pkg::POS_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ths_chan_if.sink   tick,
    ths_chan_if.sink   cfg,
    ths_chan_if.source result
);
    import ths_pkg::*;

    localparam int EXT_W = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

    logic [PERIOD_W-1:0] step_period_reg;
    logic [PERIOD_W-1:0] z_backoff_per_reg;
    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [STEPS_W-1:0]  backoff_xy_reg;
    logic [STEPS_W-1:0]  backoff_z_reg;

    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       all_done, all_idle, z_done, arm;
    tick_t      req;

    axis_ctrl_t ctrl_x, ctrl_z;
    axis_stat_t stat_x, stat_y, stat_z;
    logic [POS_WIDTH-1:0] pos_x, pos_y, pos_z;
    logic [EXT_W-1:0]     ext_x, ext_y, ext_z;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg   <= RST_STEP_PERIOD;
            z_backoff_per_reg <= RST_Z_BACKOFF_PER;
            settle_ticks_reg  <= RST_SETTLE;
            backoff_xy_reg    <= RST_BACKOFF_XY;
            backoff_z_reg     <= RST_BACKOFF_Z;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_STEP_PERIOD:   step_period_reg   <= cfg.data.value[PERIOD_W-1:0];
                CFG_Z_BACKOFF_PER: z_backoff_per_reg <= cfg.data.value[PERIOD_W-1:0];
                CFG_SETTLE:        settle_ticks_reg  <= cfg.data.value[SETTLE_W-1:0];
                CFG_BACKOFF_XY:    backoff_xy_reg    <= cfg.data.value[STEPS_W-1:0];
                CFG_BACKOFF_Z:     backoff_z_reg     <= cfg.data.value[STEPS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake: the axis state registers double as the result register
    assign tick.ready     = !out_valid_reg || result.ready;
    assign accept         = tick.valid && tick.ready;
    assign out_valid_next = accept ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // sequencing across axes
    assign req      = tick.data;
    assign all_done = stat_x.phase == PH_DONE && stat_y.phase == PH_DONE
                      && stat_z.phase == PH_DONE;
    assign all_idle = stat_x.phase == PH_IDLE && stat_y.phase == PH_IDLE
                      && stat_z.phase == PH_IDLE;
    assign z_done   = stat_z.phase == PH_DONE;
    assign arm      = req.start_req && (all_done || all_idle);

    assign ctrl_x.tick     = accept;
    assign ctrl_x.arm      = arm;
    assign ctrl_x.arm_seek = 1'b0;
    assign ctrl_x.resume   = z_done;

    assign ctrl_z.tick     = accept;
    assign ctrl_z.arm      = arm;
    assign ctrl_z.arm_seek = 1'b1;
    assign ctrl_z.resume   = 1'b0;

    ths_axis #(.POS_WIDTH(POS_WIDTH), .SEEK_POS(1'b1)) u_axis_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_x),
        .sw_open      (req.x_max_open),
        .period       (step_period_reg),
        .steps        (backoff_xy_reg),
        .settle_ticks (settle_ticks_reg),
        .stat         (stat_x),
        .pos          (pos_x)
    );

    ths_axis #(.POS_WIDTH(POS_WIDTH), .SEEK_POS(1'b1)) u_axis_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_x),
        .sw_open      (req.y_max_open),
        .period       (step_period_reg),
        .steps        (backoff_xy_reg),
        .settle_ticks (settle_ticks_reg),
        .stat         (stat_y),
        .pos          (pos_y)
    );

    ths_axis #(.POS_WIDTH(POS_WIDTH), .SEEK_POS(1'b0)) u_axis_z (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_z),
        .sw_open      (req.z_min_open),
        .period       (z_backoff_per_reg),
        .steps        (backoff_z_reg),
        .settle_ticks (settle_ticks_reg),
        .stat         (stat_z),
        .pos          (pos_z)
    );

    // positions sign-extended or truncated to the result width
    assign ext_x = EXT_W'(signed'(pos_x));
    assign ext_y = EXT_W'(signed'(pos_y));
    assign ext_z = EXT_W'(signed'(pos_z));

    assign result.valid       = out_valid_reg;
    assign result.data.x_step = stat_x.step;
    assign result.data.x_dir  = stat_x.dir;
    assign result.data.y_step = stat_y.step;
    assign result.data.y_dir  = stat_y.dir;
    assign result.data.z_step = stat_z.step;
    assign result.data.z_dir  = stat_z.dir;
    assign result.data.homed  = all_done;
    assign result.data.x_pos  = ext_x[OUT_POS_W-1:0];
    assign result.data.y_pos  = ext_y[OUT_POS_W-1:0];
    assign result.data.z_pos  = ext_z[OUT_POS_W-1:0];

endmodule

// ----- design/ths_axis.sv -----
// ----------------------------------------------------------------------------
// ths_axis: one homing axis
// Wait if so armed, then seek, settle, back off and zero; holds the axis state and its position.
// ----------------------------------------------------------------------------
module ths_axis #(
    parameter int   POS_WIDTH = ths_pkg::POS_WIDTH_DEF,
    parameter logic SEEK_POS  = 1'b1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ths_pkg::axis_ctrl_t            ctrl,
    input  logic                           sw_open,
    input  logic [ths_pkg::PERIOD_W-1:0]   period,
    input  logic [ths_pkg::STEPS_W-1:0]    steps,
    input  logic [ths_pkg::SETTLE_W-1:0]   settle_ticks,
    output ths_pkg::axis_stat_t            stat,
    output logic [POS_WIDTH-1:0]           pos
);
    import ths_pkg::*;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [SETTLE_W-1:0]  settle_reg, settle_next;
    logic [STEPS_W-1:0]   backoff_reg, backoff_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                 step_reg, step_next;

    logic [PHASE_W-1:0]   ph;
    logic [PERIOD_W-1:0]  pc;
    logic [PERIOD_W-1:0]  reload;

    // a zero period acts as one
    assign reload = (period == '0) ? '0 : period - PERIOD_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        period_next  = period_reg;
        settle_next  = settle_reg;
        backoff_next = backoff_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        ph           = phase_reg;
        pc           = period_reg;
        if (ctrl.tick)
        begin
            step_next = 1'b0;
            if (ctrl.arm)
            begin
                phase_next   = ctrl.arm_seek ? PH_SEEK : PH_WAIT;
                period_next  = '0;
                settle_next  = '0;
                backoff_next = '0;
            end
            else
            begin
                // leaving wait runs the first seek decision in the same tick
                if (ph == PH_WAIT && ctrl.resume)
                begin
                    ph = PH_SEEK;
                    pc = '0;
                end
                phase_next  = ph;
                period_next = pc;
                case (ph)
                    PH_SEEK:
                    begin
                        if (!sw_open)
                        begin
                            phase_next  = PH_SETTLE;
                            settle_next = '0;
                        end
                        else if (pc == '0)
                        begin
                            step_next   = 1'b1;
                            period_next = reload;
                        end
                        else
                        begin
                            period_next = pc - PERIOD_W'(1);
                        end
                    end
                    PH_SETTLE:
                    begin
                        if (settle_reg >= settle_ticks)
                        begin
                            phase_next   = PH_BACKOFF;
                            backoff_next = steps;
                            period_next  = '0;
                        end
                        else
                        begin
                            settle_next = settle_reg + SETTLE_W'(1);
                        end
                    end
                    PH_BACKOFF:
                    begin
                        if (backoff_reg == '0)
                        begin
                            pos_next   = '0;
                            phase_next = PH_DONE;
                        end
                        else if (pc == '0)
                        begin
                            step_next    = 1'b1;
                            backoff_next = backoff_reg - STEPS_W'(1);
                            period_next  = reload;
                        end
                        else
                        begin
                            period_next = pc - PERIOD_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (step_next)
                begin
                    if ((ph == PH_BACKOFF) ? !SEEK_POS : SEEK_POS)
                        pos_next = pos_reg + POS_WIDTH'(1);
                    else
                        pos_next = pos_reg - POS_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            period_reg  <= '0;
            settle_reg  <= '0;
            backoff_reg <= '0;
            pos_reg     <= '0;
            step_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            settle_reg  <= settle_next;
            backoff_reg <= backoff_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
        end
    end

    assign stat.phase = phase_reg;
    assign stat.step  = step_reg;
    assign stat.dir   = (phase_reg == PH_BACKOFF) ? !SEEK_POS : SEEK_POS;
    assign pos        = pos_reg;

endmodule
